### rtl/compass_heading_from_xy_top_macros.svh
// Assertion macros for the compass heading block.
`ifndef COMPASS_HEADING_FROM_XY_TOP_MACROS_SVH
`define COMPASS_HEADING_FROM_XY_TOP_MACROS_SVH

`ifndef ASSERT_OFF
`define CHXY_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
`define CHXY_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define CHXY_ASSERT(lbl, prop, msg)
`define CHXY_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

### rtl/chxy_pkg.sv
// Shared types, constants and the arctangent table of the compass heading block.
package chxy_pkg;

  localparam int CORDIC_STEPS = 16;
  localparam int TABLE_LEN    = 24;
  localparam int NUM_ITER     = (CORDIC_STEPS < TABLE_LEN) ? CORDIC_STEPS : TABLE_LEN;
  localparam int STEP_W       = $clog2(TABLE_LEN);

  localparam int IN_W   = 16;
  localparam int PRESCALE = 8;
  localparam int VW     = 27;
  localparam int ZW     = 26;
  localparam int AW     = 16;
  localparam int HW     = 19;
  localparam int OUT_W  = 16;
  localparam int FINE_SHIFT = 8;

  localparam logic signed [AW-1:0] HALF_TURN    = 16'sd23040;
  localparam logic signed [AW-1:0] QUARTER_TURN = 16'sd11520;
  localparam logic signed [HW-1:0] FULL_TURN    = 19'sd46080;
  localparam logic signed [HW-1:0] TWO_TURNS    = 19'sd92160;
  localparam logic signed [ZW-1:0] FINE_HALF_TURN = 26'sd5898240;
  localparam logic signed [ZW-1:0] ROUND_BIAS   = 26'sd128;
  localparam logic signed [IN_W-1:0] DECL_RESET = 16'sd733;

  typedef struct packed {
    logic                   special;
    logic signed [AW-1:0]   spec_angle;
    logic signed [VW-1:0]   x;
    logic signed [VW-1:0]   y;
    logic signed [ZW-1:0]   z;
  } chxy_data_t;

  function automatic logic signed [ZW-1:0] chxy_atan(input logic [STEP_W-1:0] step);
    logic signed [ZW-1:0] r;
    case (step)
      5'd0:  r = 26'sd1474560;
      5'd1:  r = 26'sd870484;
      5'd2:  r = 26'sd459940;
      5'd3:  r = 26'sd233473;
      5'd4:  r = 26'sd117189;
      5'd5:  r = 26'sd58652;
      5'd6:  r = 26'sd29333;
      5'd7:  r = 26'sd14667;
      5'd8:  r = 26'sd7334;
      5'd9:  r = 26'sd3667;
      5'd10: r = 26'sd1833;
      5'd11: r = 26'sd917;
      5'd12: r = 26'sd458;
      5'd13: r = 26'sd229;
      5'd14: r = 26'sd115;
      5'd15: r = 26'sd57;
      5'd16: r = 26'sd29;
      5'd17: r = 26'sd14;
      5'd18: r = 26'sd7;
      5'd19: r = 26'sd4;
      5'd20: r = 26'sd2;
      5'd21: r = 26'sd1;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

### rtl/chxy_prep.sv
// Input stage: axis special cases, half-turn fold and scaling into the CORDIC format.
module chxy_prep (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     en_i,
  input  logic                     valid_i,
  input  logic signed [15:0]       x_value_i,
  input  logic signed [15:0]       y_value_i,
  output logic                     valid_o,
  output chxy_pkg::chxy_data_t     data_o
);
  import chxy_pkg::*;

  logic                  valid_q;
  chxy_data_t            data_d, data_q;
  logic                  x_zero, y_zero, x_neg;
  logic signed [IN_W:0]  xn, yn;

  always_comb begin
    x_zero = (x_value_i == '0);
    y_zero = (y_value_i == '0);
    x_neg  = x_value_i[IN_W-1];
    xn = x_neg ? -{x_value_i[IN_W-1], x_value_i} : {x_value_i[IN_W-1], x_value_i};
    yn = x_neg ? -{y_value_i[IN_W-1], y_value_i} : {y_value_i[IN_W-1], y_value_i};

    data_d.special = x_zero || y_zero;
    if (y_zero) begin
      data_d.spec_angle = x_neg ? HALF_TURN : '0;
    end else begin
      data_d.spec_angle = y_value_i[IN_W-1] ? -QUARTER_TURN : QUARTER_TURN;
    end
    data_d.x = {{(VW-IN_W-1-PRESCALE){xn[IN_W]}}, xn, {PRESCALE{1'b0}}};
    data_d.y = {{(VW-IN_W-1-PRESCALE){yn[IN_W]}}, yn, {PRESCALE{1'b0}}};
    if (x_neg) begin
      data_d.z = y_value_i[IN_W-1] ? -FINE_HALF_TURN : FINE_HALF_TURN;
    end else begin
      data_d.z = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

### rtl/chxy_cordic_stage.sv
// One registered vectoring CORDIC iteration.
module chxy_cordic_stage (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  logic [chxy_pkg::STEP_W-1:0]   step_i,
  input  logic                          valid_i,
  input  chxy_pkg::chxy_data_t          data_i,
  output logic                          valid_o,
  output chxy_pkg::chxy_data_t          data_o
);
  import chxy_pkg::*;

  logic                  valid_q;
  chxy_data_t            data_d, data_q;
  logic signed [VW-1:0]  xs, ys;
  logic signed [ZW-1:0]  da;

  always_comb begin
    xs = data_i.x >>> step_i;
    ys = data_i.y >>> step_i;
    da = chxy_atan(step_i);
    data_d = data_i;
    if (!data_i.y[VW-1] && (data_i.y != '0)) begin
      data_d.x = data_i.x + ys;
      data_d.y = data_i.y - xs;
      data_d.z = data_i.z + da;
    end else begin
      data_d.x = data_i.x - ys;
      data_d.y = data_i.y + xs;
      data_d.z = data_i.z - da;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

### rtl/chxy_post.sv
// Output stages: angle rounding, declination add and fold into one turn.
module chxy_post (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     en_i,
  input  logic                     valid_i,
  input  chxy_pkg::chxy_data_t     data_i,
  input  logic signed [15:0]       decl_i,
  output logic                     valid_o,
  output logic [15:0]              heading_o
);
  import chxy_pkg::*;

  logic signed [ZW-1:0]             zb;
  logic signed [ZW-FINE_SHIFT-1:0]  angle;
  logic signed [HW-1:0]             sum_d, sum_q;
  logic                             valid_a_q, valid_q;
  logic signed [HW-1:0]             c_one, c_two, c_sub, fold;
  logic [OUT_W-1:0]                 heading_q;

  always_comb begin
    zb = data_i.z + ROUND_BIAS;
    if (data_i.special) begin
      angle = {{(ZW-FINE_SHIFT-AW){data_i.spec_angle[AW-1]}}, data_i.spec_angle};
    end else begin
      angle = zb[ZW-1:FINE_SHIFT];
    end
    sum_d = {{(HW-ZW+FINE_SHIFT){angle[ZW-FINE_SHIFT-1]}}, angle}
          + {{(HW-IN_W){decl_i[IN_W-1]}}, decl_i};
  end

  always_comb begin
    c_one = sum_q + FULL_TURN;
    c_two = sum_q + TWO_TURNS;
    c_sub = sum_q - FULL_TURN;
    if (sum_q[HW-1]) begin
      fold = c_one[HW-1] ? c_two : c_one;
    end else if (sum_q > FULL_TURN) begin
      fold = c_sub;
    end else begin
      fold = sum_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_a_q <= 1'b0;
      valid_q   <= 1'b0;
    end else if (en_i) begin
      valid_a_q <= valid_i;
      valid_q   <= valid_a_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sum_q     <= sum_d;
      heading_q <= fold[OUT_W-1:0];
    end
  end

  assign valid_o   = valid_q;
  assign heading_o = heading_q;

endmodule

### rtl/compass_heading_from_xy_top.sv
// A word passes the prep, NUM_ITER iteration, sum, heading and output registers to valid_o.
// Throughput: one word per cycle while stall_o is low; every CORDIC iteration has its own register stage.
// stall_o is the registered skid slot flag, so stall_i reaches the input side only via a register.
// Reset clears all valid bits and loads the declination with 733 (0.1 rad).
// Top level of the compass heading block.
`include "compass_heading_from_xy_top_macros.svh"
module compass_heading_from_xy_top (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               decl_we_i,
  input  logic signed [15:0] decl_wdata_i,
  input  logic               valid_i,
  output logic               stall_o,
  input  logic signed [15:0] x_value_i,
  input  logic signed [15:0] y_value_i,
  output logic               valid_o,
  input  logic               stall_i,
  output logic [15:0]        heading_o
);
  import chxy_pkg::*;

  logic signed [IN_W-1:0] decl_q;
  logic                   en, take, arrive;
  logic                   stage_valid [NUM_ITER+1];
  chxy_data_t             stage_data  [NUM_ITER+1];
  logic                   post_valid;
  logic [OUT_W-1:0]       post_heading;
  logic                   out_valid_d, out_valid_q, skid_valid_d, skid_valid_q;
  logic [OUT_W-1:0]       out_d, out_q, skid_d, skid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      decl_q <= DECL_RESET;
    end else if (decl_we_i) begin
      decl_q <= decl_wdata_i;
    end
  end

  assign en      = !skid_valid_q;
  assign stall_o = skid_valid_q;

  chxy_prep u_prep (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (en),
    .valid_i   (valid_i),
    .x_value_i (x_value_i),
    .y_value_i (y_value_i),
    .valid_o   (stage_valid[0]),
    .data_o    (stage_data[0])
  );

  for (genvar i = 0; i < NUM_ITER; i++) begin : g_iter
    chxy_cordic_stage u_stage (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .step_i  (STEP_W'(i)),
      .valid_i (stage_valid[i]),
      .data_i  (stage_data[i]),
      .valid_o (stage_valid[i+1]),
      .data_o  (stage_data[i+1])
    );
  end

  chxy_post u_post (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (en),
    .valid_i   (stage_valid[NUM_ITER]),
    .data_i    (stage_data[NUM_ITER]),
    .decl_i    (decl_q),
    .valid_o   (post_valid),
    .heading_o (post_heading)
  );

  assign take   = out_valid_q && !stall_i;
  assign arrive = en && post_valid;

  always_comb begin
    out_valid_d  = out_valid_q;
    out_d        = out_q;
    skid_valid_d = skid_valid_q;
    skid_d       = skid_q;
    if (skid_valid_q) begin
      if (take) begin
        out_d        = skid_q;
        skid_valid_d = 1'b0;
      end
    end else if (!out_valid_q || !stall_i) begin
      out_valid_d = arrive;
      out_d       = post_heading;
    end else if (arrive) begin
      skid_valid_d = 1'b1;
      skid_d       = post_heading;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign valid_o   = out_valid_q;
  assign heading_o = out_q;

  `CHXY_ASSERT(a_heading_range, !valid_o || (heading_o <= 16'd46080), "heading above one turn")
  `CHXY_ASSERT(a_skid_needs_out, !skid_valid_q || out_valid_q, "skid word without output word")
  `CHXY_ASSERT_NEXT(a_skid_drains, skid_valid_q && !stall_i,
                    out_valid_q && !skid_valid_q, "skid did not drain")
  `CHXY_ASSERT_NEXT(a_skid_fills, out_valid_q && stall_i && !skid_valid_q && post_valid,
                    skid_valid_q, "word lost on held output")

endmodule

### dv/tb_compass_heading_from_xy_top.sv
// Self-checking testbench for the compass heading block: directed table, then random words.
module tb_compass_heading_from_xy_top;
  import chxy_pkg::*;

  localparam longint TURN       = 46080;
  localparam longint HALF       = 23040;
  localparam longint QUARTER    = 11520;
  localparam longint FINE_HALF  = 5898240;
  localparam int     N_DIR      = 26;
  localparam int     N_RAND     = 1650;
  localparam int     N_PHASE    = 6;
  localparam int     MAX_REPORT = 10;
  localparam int     SETTLE     = NUM_ITER + 8;

  typedef struct packed {
    logic signed [15:0] decl;
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic               typed;
    logic [15:0]        heading;
  } dir_row_t;

  typedef struct packed {
    logic [15:0]        heading;
    logic signed [15:0] x;
    logic signed [15:0] y;
  } heading_exp_t;

  logic               clk_i        = 1'b0;
  logic               rst_ni       = 1'b0;
  logic               decl_we_i    = 1'b0;
  logic signed [15:0] decl_wdata_i = '0;
  logic               valid_i      = 1'b0;
  logic               stall_o;
  logic signed [15:0] x_value_i    = '0;
  logic signed [15:0] y_value_i    = '0;
  logic               valid_o;
  logic               stall_i      = 1'b0;
  logic [15:0]        heading_o;

  heading_exp_t       heading_q[$];
  heading_exp_t       got_exp;
  logic signed [15:0] decl_cur = 16'sd733;
  int                 n_checked = 0;
  int                 n_bad = 0;
  int                 n_axis = 0;
  int                 n_decl = 0;
  int                 rx_hold = 0;
  bit                 rx_calm = 1'b0;
  bit                 tx_calm = 1'b0;

  compass_heading_from_xy_top dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .decl_we_i    (decl_we_i),
    .decl_wdata_i (decl_wdata_i),
    .valid_i      (valid_i),
    .stall_o      (stall_o),
    .x_value_i    (x_value_i),
    .y_value_i    (y_value_i),
    .valid_o      (valid_o),
    .stall_i      (stall_i),
    .heading_o    (heading_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  initial begin
    #5000000;
    $display("FAIL");
    $finish;
  end

  function automatic longint atan_fine(input int i);
    case (i)
      0:  return 1474560;
      1:  return 870484;
      2:  return 459940;
      3:  return 233473;
      4:  return 117189;
      5:  return 58652;
      6:  return 29333;
      7:  return 14667;
      8:  return 7334;
      9:  return 3667;
      10: return 1833;
      11: return 917;
      12: return 458;
      13: return 229;
      14: return 115;
      15: return 57;
      16: return 29;
      17: return 14;
      18: return 7;
      19: return 4;
      20: return 2;
      21: return 1;
      default: return 0;
    endcase
  endfunction

  function automatic logic [15:0] heading_of(input logic signed [15:0] xr,
                                             input logic signed [15:0] yr,
                                             input logic signed [15:0] decl);
    longint vx, vy, sx, sy, acc, ang, hd;
    vx  = longint'(xr);
    vy  = longint'(yr);
    acc = 0;
    if (vy == 0) begin
      ang = (vx < 0) ? HALF : 0;
    end else if (vx == 0) begin
      ang = (vy > 0) ? QUARTER : -QUARTER;
    end else begin
      if (vx < 0) begin
        vx  = -vx;
        vy  = -vy;
        acc = (vy < 0) ? FINE_HALF : -FINE_HALF;
      end
      vx = vx * 256;
      vy = vy * 256;
      for (int i = 0; i < NUM_ITER; i++) begin
        sx = vx >>> i;
        sy = vy >>> i;
        if (vy > 0) begin
          vx  = vx + sy;
          vy  = vy - sx;
          acc = acc + atan_fine(i);
        end else begin
          vx  = vx - sy;
          vy  = vy + sx;
          acc = acc - atan_fine(i);
        end
      end
      ang = (acc + 128) >>> 8;
    end
    hd = ang + longint'(decl);
    if (hd < 0) hd = hd + TURN;
    if (hd < 0) hd = hd + TURN;
    if (hd > TURN) hd = hd - TURN;
    return hd[15:0];
  endfunction

  function automatic dir_row_t dir_row(input int k);
    dir_row_t r;
    case (k)
      0:  r = '{733, 0, 0, 1'b1, 733};
      1:  r = '{733, 1, 0, 1'b1, 733};
      2:  r = '{733, -1, 0, 1'b1, 23773};
      3:  r = '{733, 0, 1, 1'b1, 12253};
      4:  r = '{733, 0, -1, 1'b1, 35293};
      5:  r = '{733, 32767, 0, 1'b1, 733};
      6:  r = '{733, -32768, 0, 1'b1, 23773};
      7:  r = '{733, 0, 32767, 1'b1, 12253};
      8:  r = '{733, 0, -32768, 1'b1, 35293};
      9:  r = '{733, 32767, 32767, 1'b0, 0};
      10: r = '{733, -32768, -32768, 1'b0, 0};
      11: r = '{733, -32768, 32767, 1'b0, 0};
      12: r = '{733, 32767, -32768, 1'b0, 0};
      13: r = '{733, -1, 1, 1'b0, 0};
      14: r = '{733, -1, -1, 1'b0, 0};
      15: r = '{733, 1, -1, 1'b0, 0};
      16: r = '{733, -300, 7, 1'b0, 0};
      17: r = '{23040, -1, 0, 1'b1, 46080};
      18: r = '{23040, 0, 1, 1'b1, 34560};
      19: r = '{23040, 32767, -1, 1'b0, 0};
      20: r = '{-23040, 0, 0, 1'b1, 23040};
      21: r = '{-23040, 0, -1, 1'b1, 11520};
      22: r = '{-32768, -32768, -1, 1'b0, 0};
      23: r = '{-32768, 0, -1, 1'b1, 1792};
      24: r = '{32767, 0, 1, 1'b1, 44287};
      default: r = '{32767, -1, 0, 1'b1, 9727};
    endcase
    return r;
  endfunction

  function automatic logic signed [15:0] rand_reading();
    logic [31:0] r;
    r = $urandom;
    case ($urandom_range(0, 9))
      0: return 16'h0000;
      1: begin
        case (r[1:0])
          2'd0:    return 16'h8000;
          2'd1:    return 16'h7FFF;
          2'd2:    return 16'hFFFF;
          default: return 16'h0001;
        endcase
      end
      2: return {{10{r[5]}}, r[5:0]};
      default: return r[15:0];
    endcase
  endfunction

  function automatic int draw_wait(input bit calm);
    return calm ? 0 : $urandom_range(0, 10);
  endfunction

  task automatic drain();
    valid_i <= 1'b0;
    while (heading_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic set_declination(input logic signed [15:0] dv);
    drain();
    decl_we_i    <= 1'b1;
    decl_wdata_i <= dv;
    @(posedge clk_i);
    decl_we_i <= 1'b0;
    decl_cur = dv;
    n_decl++;
  endtask

  task automatic send_word(input logic signed [15:0] xr, input logic signed [15:0] yr,
                           input logic typed, input logic [15:0] hd);
    int           gap;
    heading_exp_t e;
    if ($urandom_range(0, 19) == 0) tx_calm = !tx_calm;
    gap = draw_wait(tx_calm);
    if (gap > 0) begin
      valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    valid_i   <= 1'b1;
    x_value_i <= xr;
    y_value_i <= yr;
    e.heading = typed ? hd : heading_of(xr, yr, decl_cur);
    e.x = xr;
    e.y = yr;
    do @(posedge clk_i); while (stall_o);
    heading_q.push_back(e);
    if (xr == 0 || yr == 0) n_axis++;
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (valid_o && !stall_i) begin
        if (heading_q.size() == 0) begin
          n_bad++;
          if (n_bad <= MAX_REPORT) $display("unexpected heading word %0d", heading_o);
        end else begin
          got_exp = heading_q.pop_front();
          n_checked++;
          if (heading_o !== got_exp.heading) begin
            n_bad++;
            if (n_bad <= MAX_REPORT) begin
              $display("heading mismatch x=%0d y=%0d: expected %0d, got %0d",
                       got_exp.x, got_exp.y, got_exp.heading, heading_o);
            end
          end
        end
        if ($urandom_range(0, 19) == 0) rx_calm = !rx_calm;
        rx_hold = draw_wait(rx_calm);
      end else if (rx_hold > 0) begin
        rx_hold = rx_hold - 1;
      end
      stall_i <= (rx_hold > 0);
    end
  end

  initial begin
    dir_row_t           row;
    logic signed [15:0] dv;
    rst_ni <= 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int k = 0; k < N_DIR; k++) begin
      row = dir_row(k);
      if (row.decl != decl_cur) set_declination(row.decl);
      send_word(row.x, row.y, row.typed, row.heading);
    end

    for (int ph = 0; ph < N_PHASE; ph++) begin
      case (ph)
        0:       dv = 16'sd0;
        1:       dv = -16'sd23040;
        2:       dv = 16'sd23040;
        4:       dv = 16'($urandom);
        default: dv = 16'($urandom_range(0, 46080) - 23040);
      endcase
      set_declination(dv);
      for (int k = 0; k < N_RAND / N_PHASE; k++) begin
        if ($urandom_range(0, 199) == 0) drain();
        send_word(rand_reading(), rand_reading(), 1'b0, 16'd0);
      end
    end

    drain();
    $display("checked %0d headings under %0d declination settings", n_checked, n_decl + 1);
    $display("%0d inputs lay on an axis or at the origin", n_axis);
    if (n_bad == 0) begin
      $display("PASS");
    end else begin
      $display("%0d heading errors", n_bad);
      $display("FAIL");
    end
    $finish;
  end

endmodule

### filelist.f
+incdir+rtl
rtl/chxy_pkg.sv
rtl/chxy_prep.sv
rtl/chxy_cordic_stage.sv
rtl/chxy_post.sv
rtl/compass_heading_from_xy_top.sv
dv/tb_compass_heading_from_xy_top.sv
